[src/mst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multimode slot timer
// Command codes, mode and register codes, the queued slot entry, the control
// bundle of the slot queue and one result record.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int TICKS_W = 24;
	localparam int TAG_W   = 16;
	localparam int STAMP_W = 32;
	localparam int ADDR_W  = 8;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SUSPEND = 3'd2,
		CMD_RESUME  = 3'd3,
		CMD_DISABLE = 3'd4
	} cmd_t;

	localparam logic [1:0] MODE_ONE_SHOT = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_SLOT     = 2'd2;

	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_DURATION = 2'd1;
	localparam logic [1:0] CFG_RESERVED = 2'd2;

	localparam logic EV_EXPIRY = 1'b0;
	localparam logic EV_FLAG   = 1'b1;

	localparam logic [TICKS_W-1:0] DURATION_RESET = 24'd1000;

	// Result buffer: room for the two results of one item plus two in flight.
	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = 2;
	localparam int RES_CW    = 3;

	typedef struct packed {
		logic [TICKS_W-1:0] len;
		logic               flag;
	} slot_entry_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		logic        clear;
		slot_entry_t entry;
	} queue_ctl_t;

	typedef struct packed {
		logic               event_kind;
		logic               killed;
		logic               slot_flag;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

[src/mst_slot_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_slot_queue: circular queue of slot lengths and flags
// Keeps the head entry and the entry behind it in registers so that a slot
// end can load the following slot without a combinational memory read.
// ----------------------------------------------------------------------------
module mst_slot_queue #(
	parameter int DEPTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  mst_pkg::queue_ctl_t         ctl,
	output logic [$clog2(DEPTH+1)-1:0]  count,
	output mst_pkg::slot_entry_t        head_entry,
	output mst_pkg::slot_entry_t        next_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = ((AW > CW) ? AW : CW) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

	mst_pkg::slot_entry_t mem [DEPTH];
	mst_pkg::slot_entry_t head_entry_q;
	mst_pkg::slot_entry_t rd_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	logic [AW-1:0] tail;
	logic [AW-1:0] rd_addr;
	logic [SW-1:0] tail_sum;

	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : AW'(a + 1'b1);
	endfunction

	always_comb begin
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= DEPTH_S) begin
			tail_sum = tail_sum - DEPTH_S;
		end
		tail = tail_sum[AW-1:0];

		head_d  = head_q;
		count_d = count_q;
		if (ctl.clear) begin
			head_d  = '0;
			count_d = '0;
		end else if (ctl.pop) begin
			head_d  = addr_inc(head_q);
			count_d = count_q - 1'b1;
		end else if (ctl.push) begin
			count_d = count_q + 1'b1;
		end
		// The entry behind the head of the next cycle is fetched now.
		rd_addr = addr_inc(head_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear) begin
			mem[tail] <= ctl.entry;
		end
		if (ctl.push && !ctl.clear && (tail == rd_addr)) begin
			rd_q <= ctl.entry;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear && (count_q == '0)) begin
			head_entry_q <= ctl.entry;
		end else if (ctl.pop && !ctl.clear) begin
			head_entry_q <= rd_q;
		end
	end

	assign count      = count_q;
	assign head_entry = head_entry_q;
	assign next_entry = rd_q;

endmodule
`default_nettype wire

[src/mst_result_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_result_fifo: output buffer for result records
// Takes up to two results in a cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module mst_result_fifo (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push0,
	input  wire                              push1,
	input  mst_pkg::result_t                 res0,
	input  mst_pkg::result_t                 res1,
	input  wire                              pop,
	output logic                             has_room,
	output logic                             not_empty,
	output mst_pkg::result_t                 head
);

	mst_pkg::result_t mem_q [mst_pkg::RES_DEPTH];
	logic [mst_pkg::RES_PW-1:0] wr_ptr_q;
	logic [mst_pkg::RES_PW-1:0] rd_ptr_q;
	logic [mst_pkg::RES_CW-1:0] count_q;
	logic [mst_pkg::RES_CW-1:0] n_push;
	logic                       do_pop;

	always_comb begin
		do_pop = pop && (count_q != '0);
		n_push = mst_pkg::RES_CW'(push0) + mst_pkg::RES_CW'(push1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mst_pkg::RES_PW'(n_push);
			rd_ptr_q <= rd_ptr_q + mst_pkg::RES_PW'(do_pop);
			count_q  <= count_q + n_push - mst_pkg::RES_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	assign has_room  = count_q <= mst_pkg::RES_CW'(mst_pkg::RES_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

[src/multimode_slot_timer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multimode_slot_timer: command-driven one-shot, periodic and slot timer
// Top level: input register, command decode and timer state, result buffer.
// ----------------------------------------------------------------------------
// Usage
// Commands arrive on the input channel (in_valid/in_ready), one per
// transaction: tick, start, suspend, resume or disable. Each command gives
// zero, one or two result records on the output channel (out_valid/out_ready);
// the final record of a command carries last. The user must write registers
// through the cfg channel, which is always ready, only while no command is in
// flight; the block itself does not enforce this. A command accepted at a
// clock edge is decoded in the following cycle; its results are written to a
// four-entry result buffer once it has room, and the output channel offers them.
// Throughput: one command per cycle while the buffer has room for two
// results; the sustained rate is then bounded only by the output channel,
// which delivers one result per cycle while out_ready is high.
// Stall: when the receiver holds out_ready low the buffer fills and in_ready
// falls once fewer than two entries are free; nothing is dropped.
// Reset: arst_n clears the timer state, the slot queue pointers, the tick
// clock and the buffer; registers return to one-shot mode, a duration of
// 1000 ticks and no reserved ticks.
// ----------------------------------------------------------------------------
module multimode_slot_timer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [1:0]                      cfg_index,
	input  wire  [mst_pkg::TICKS_W-1:0]     cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [2:0]                      command,
	input  wire  [mst_pkg::TICKS_W-1:0]     slot_ticks,
	input  wire  [mst_pkg::ADDR_W-1:0]      node_address,
	input  wire                             slot_check,
	input  wire  [mst_pkg::TAG_W-1:0]       frame_tag,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            event_kind,
	output logic                            killed,
	output logic                            slot_flag,
	output logic [mst_pkg::TAG_W-1:0]       tag_out,
	output logic [mst_pkg::STAMP_W-1:0]     event_time,
	output logic                            last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);

	// Configuration registers.
	logic [1:0]                  mode_q;
	logic [mst_pkg::TICKS_W-1:0] duration_q;
	logic [mst_pkg::TICKS_W-1:0] reserved_q;

	// Input stage.
	logic                         valid_s1;
	logic [2:0]                   cmd_s1;
	logic [mst_pkg::TICKS_W-1:0]  slot_s1;
	logic [mst_pkg::ADDR_W-1:0]   addr_s1;
	logic                         chk_s1;
	logic [mst_pkg::TAG_W-1:0]    tag_s1;

	// Timer state.
	logic                         active_q, active_d;
	logic                         disabled_q, disabled_d;
	logic                         counting_q, counting_d;
	logic [mst_pkg::TICKS_W-1:0]  remaining_q, remaining_d;
	logic [mst_pkg::TAG_W-1:0]    saved_tag_q, saved_tag_d;
	logic [mst_pkg::STAMP_W-1:0]  tick_clock_q, tick_clock_d;

	mst_pkg::queue_ctl_t  q_ctl, q_ctl_d;
	mst_pkg::slot_entry_t q_head, q_next, new_entry, head_val;
	logic [CW-1:0]        q_count;

	mst_pkg::result_t res0, res1, fifo_head;
	logic             v0, v1;
	logic             fifo_room, fifo_ne;
	logic             adv_s1;
	logic             clear_req;

	function automatic logic [mst_pkg::TICKS_W-1:0] slot_load(
		input logic [mst_pkg::TICKS_W-1:0] len,
		input logic [mst_pkg::TICKS_W-1:0] rsv
	);
		return (len > rsv) ? (len - rsv) : '0;
	endfunction

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && fifo_room;
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= mst_pkg::MODE_ONE_SHOT;
			duration_q <= mst_pkg::DURATION_RESET;
			reserved_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				mst_pkg::CFG_MODE:     mode_q     <= cfg_data[1:0];
				mst_pkg::CFG_DURATION: duration_q <= cfg_data;
				mst_pkg::CFG_RESERVED: reserved_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= command;
			slot_s1 <= slot_ticks;
			addr_s1 <= node_address;
			chk_s1  <= slot_check;
			tag_s1  <= frame_tag;
		end
	end

	always_comb begin
		active_d     = active_q;
		disabled_d   = disabled_q;
		counting_d   = counting_q;
		remaining_d  = remaining_q;
		saved_tag_d  = saved_tag_q;
		tick_clock_d = tick_clock_q;
		q_ctl_d      = '0;
		v0           = 1'b0;
		v1           = 1'b0;
		res0         = '0;
		res1         = '0;

		new_entry.len  = slot_s1;
		new_entry.flag = chk_s1;
		q_ctl_d.entry  = new_entry;
		// After a push into an empty queue the new slot is the head.
		head_val  = (q_count == '0) ? new_entry : q_head;
		clear_req = (addr_s1 == '0) && (slot_s1 == '0) && !chk_s1;

		case (cmd_s1)
			mst_pkg::CMD_TICK: begin
				tick_clock_d = tick_clock_q + 1'b1;
				if (counting_q) begin
					if (remaining_q > mst_pkg::TICKS_W'(1)) begin
						remaining_d = remaining_q - 1'b1;
					end else if (mode_q == mst_pkg::MODE_PERIODIC) begin
						v0               = 1'b1;
						res0.event_kind  = mst_pkg::EV_EXPIRY;
						remaining_d      = duration_q;
					end else if (mode_q == mst_pkg::MODE_SLOT) begin
						v0              = 1'b1;
						res0.event_kind = mst_pkg::EV_EXPIRY;
						v1              = 1'b1;
						res1.event_kind = mst_pkg::EV_FLAG;
						q_ctl_d.pop     = q_count != '0;
						if (q_count > CW'(1)) begin
							res1.slot_flag = q_next.flag;
							remaining_d    = slot_load(q_next.len, reserved_q);
						end else begin
							active_d    = 1'b0;
							counting_d  = 1'b0;
							remaining_d = '0;
						end
					end else begin
						v0              = 1'b1;
						res0.event_kind = mst_pkg::EV_EXPIRY;
						active_d        = 1'b0;
						counting_d      = 1'b0;
						remaining_d     = '0;
					end
				end
			end
			mst_pkg::CMD_START: begin
				if (!disabled_q) begin
					saved_tag_d = tag_s1;
					if (mode_q == mst_pkg::MODE_SLOT) begin
						if (clear_req) begin
							if (active_q && counting_q) begin
								v0              = 1'b1;
								res0.event_kind = mst_pkg::EV_EXPIRY;
								res0.killed     = 1'b1;
								v1              = 1'b1;
								res1.event_kind = mst_pkg::EV_FLAG;
							end
							active_d      = 1'b0;
							counting_d    = 1'b0;
							remaining_d   = '0;
							q_ctl_d.clear = 1'b1;
						end else if (q_count < QFULL) begin
							q_ctl_d.push = 1'b1;
							if (!active_q) begin
								active_d        = 1'b1;
								counting_d      = 1'b1;
								v0              = 1'b1;
								res0.event_kind = mst_pkg::EV_FLAG;
								res0.slot_flag  = head_val.flag;
								remaining_d     = slot_load(head_val.len, reserved_q);
							end
						end
					end else if (mode_q == mst_pkg::MODE_PERIODIC) begin
						if (!active_q) begin
							active_d    = 1'b1;
							counting_d  = 1'b1;
							remaining_d = duration_q;
						end
					end else begin
						if (!active_q) begin
							active_d   = 1'b1;
							counting_d = 1'b1;
						end
						remaining_d = duration_q;
					end
				end
			end
			mst_pkg::CMD_SUSPEND: begin
				if (active_q) begin
					if (counting_q && (mode_q == mst_pkg::MODE_PERIODIC)) begin
						v0              = 1'b1;
						res0.event_kind = mst_pkg::EV_EXPIRY;
						res0.killed     = 1'b1;
					end else if (counting_q && (mode_q == mst_pkg::MODE_SLOT)) begin
						v0              = 1'b1;
						res0.event_kind = mst_pkg::EV_EXPIRY;
						res0.killed     = 1'b1;
						v1              = 1'b1;
						res1.event_kind = mst_pkg::EV_FLAG;
						q_ctl_d.clear   = 1'b1;
					end
					active_d    = 1'b0;
					counting_d  = 1'b0;
					remaining_d = '0;
				end
			end
			mst_pkg::CMD_RESUME: begin
				active_d = 1'b1;
			end
			mst_pkg::CMD_DISABLE: begin
				disabled_d = 1'b1;
			end
			default: ;
		endcase

		res0.tag   = saved_tag_d;
		res0.stamp = tick_clock_d;
		res0.last  = !v1;
		res1.tag   = saved_tag_d;
		res1.stamp = tick_clock_d;
		res1.last  = 1'b1;

		q_ctl = adv_s1 ? q_ctl_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			disabled_q   <= 1'b0;
			counting_q   <= 1'b0;
			remaining_q  <= '0;
			saved_tag_q  <= '0;
			tick_clock_q <= '0;
		end else if (adv_s1) begin
			active_q     <= active_d;
			disabled_q   <= disabled_d;
			counting_q   <= counting_d;
			remaining_q  <= remaining_d;
			saved_tag_q  <= saved_tag_d;
			tick_clock_q <= tick_clock_d;
		end
	end

	mst_slot_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.count     (q_count),
		.head_entry(q_head),
		.next_entry(q_next)
	);

	mst_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (adv_s1 && v0),
		.push1    (adv_s1 && v1),
		.res0     (res0),
		.res1     (res1),
		.pop      (out_ready),
		.has_room (fifo_room),
		.not_empty(fifo_ne),
		.head     (fifo_head)
	);

	assign out_valid  = fifo_ne;
	assign event_kind = fifo_head.event_kind;
	assign killed     = fifo_head.killed;
	assign slot_flag  = fifo_head.slot_flag;
	assign tag_out    = fifo_head.tag;
	assign event_time = fifo_head.stamp;
	assign last       = fifo_head.last;

endmodule
`default_nettype wire

[src/mst_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mst_checker: port-level checks of the multimode slot timer
// Watches the output channel for stalls and for result records whose fields
// contradict each other.
// ----------------------------------------------------------------------------
module mst_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire                          event_kind,
	input wire                          killed,
	input wire                          slot_flag,
	input wire [mst_pkg::TAG_W-1:0]     tag_out,
	input wire [mst_pkg::STAMP_W-1:0]   event_time,
	input wire                          last
);

	// A stalled result stays offered with its tag, time, kind and last unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_out)
			&& $stable(event_time) && $stable(event_kind) && $stable(last))
	else $error("stalled result changed or withdrawn");

	// Only an expiry can be marked as killed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && killed |-> event_kind == mst_pkg::EV_EXPIRY)
	else $error("flag report marked as killed");

	// An expiry never carries a slot flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == mst_pkg::EV_EXPIRY |-> !slot_flag)
	else $error("expiry carries a slot flag");

	// A killed expiry is always followed by the end-of-schedule report or ends
	// the transaction sequence of its command on its own.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && killed && !last |=>
			out_valid && event_kind == mst_pkg::EV_FLAG && !slot_flag && last)
	else $error("killed expiry not followed by end of schedule");

endmodule

bind multimode_slot_timer mst_checker u_mst_checker (.*);
`default_nettype wire
